>>> rtl/core/descending_exchange_sort_defines.svh
// Assertion helpers used by the checker file.
`ifndef DESCENDING_EXCHANGE_SORT_DEFINES_SVH
`define DESCENDING_EXCHANGE_SORT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define DXS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DXS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dxs_pkg.sv
package dxs_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned SCORE_W     = 32;
  localparam int unsigned PAYLOAD_W   = 64;
  localparam int unsigned STEP_W      = 3;

  typedef logic [STEP_W-1:0] step_t;

  // microprogram addresses
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_SETI  = 3'd1;
  localparam step_t STEP_LDI   = 3'd2;
  localparam step_t STEP_CMP   = 3'd3;
  localparam step_t STEP_WRI   = 3'd4;
  localparam step_t STEP_OUTRD = 3'd5;
  localparam step_t STEP_OUTEM = 3'd6;
  localparam step_t STEP_FIN   = 3'd7;

  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_J,
    ADDR_I1,
    ADDR_J1
  } addr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_ONE,
    IDX_INC,
    IDX_I2
  } idx_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOAD,
    WR_CUR_I,
    WR_CUR_J
  } wr_sel_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_LAST,
    COND_J_GE_CNT,
    COND_J1_LT_CNT,
    COND_I2_LT_CNT,
    COND_I1_LT_CNT
  } cond_e;

  typedef struct packed {
    logic      busy;
    addr_sel_e addr_sel;
    idx_op_e   i_op;
    idx_op_e   j_op;
    wr_sel_e   wr_sel;
    logic      cur_ld;
    logic      emit;
    logic      clr_count;
    cond_e     cond;
    step_t     target;
  } ctrl_t;

  typedef struct packed {
    logic last_accept;
    logic j_ge_cnt;
    logic j1_lt_cnt;
    logic i2_lt_cnt;
    logic i1_lt_cnt;
  } stat_t;

  typedef struct packed {
    logic [SCORE_W-1:0]   score;
    logic [PAYLOAD_W-1:0] lo;
    logic [PAYLOAD_W-1:0] hi;
  } rec_t;

  // control store; a taken jump goes to target, otherwise to the next step
  function automatic ctrl_t ucode(step_t step);
    ctrl_t w;
    w = '{busy: 1'b1, addr_sel: ADDR_ZERO, i_op: IDX_HOLD, j_op: IDX_HOLD,
          wr_sel: WR_NONE, cur_ld: 1'b0, emit: 1'b0, clr_count: 1'b0,
          cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.busy   = 1'b0;
        w.wr_sel = WR_LOAD;
        w.cond   = COND_NOT_LAST;
        w.target = STEP_IDLE;
      end
      STEP_SETI: begin
        w.i_op     = IDX_ZERO;
        w.j_op     = IDX_ONE;
        w.addr_sel = ADDR_ZERO;
        w.cond     = COND_NEVER;
      end
      STEP_LDI: begin
        w.cur_ld   = 1'b1;
        w.addr_sel = ADDR_J;
        w.cond     = COND_J_GE_CNT;
        w.target   = STEP_WRI;
      end
      STEP_CMP: begin
        w.wr_sel   = WR_CUR_J;
        w.j_op     = IDX_INC;
        w.addr_sel = ADDR_J1;
        w.cond     = COND_J1_LT_CNT;
        w.target   = STEP_CMP;
      end
      STEP_WRI: begin
        w.wr_sel   = WR_CUR_I;
        w.i_op     = IDX_INC;
        w.j_op     = IDX_I2;
        w.addr_sel = ADDR_I1;
        w.cond     = COND_I2_LT_CNT;
        w.target   = STEP_LDI;
      end
      STEP_OUTRD: begin
        w.i_op     = IDX_ZERO;
        w.addr_sel = ADDR_ZERO;
        w.cond     = COND_NEVER;
      end
      STEP_OUTEM: begin
        w.emit     = 1'b1;
        w.i_op     = IDX_INC;
        w.addr_sel = ADDR_I1;
        w.cond     = COND_I1_LT_CNT;
        w.target   = STEP_OUTEM;
      end
      STEP_FIN: begin
        w.clr_count = 1'b1;
        w.cond      = COND_ALWAYS;
        w.target    = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/dxs_seq.sv
module dxs_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dxs_pkg::stat_t stat_i,
  output dxs_pkg::ctrl_t ctrl_o
);

  dxs_pkg::step_t upc_q, upc_d;
  dxs_pkg::ctrl_t ctrl;
  logic           take;

  assign ctrl   = dxs_pkg::ucode(upc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.cond)
      dxs_pkg::COND_NEVER:     take = 1'b0;
      dxs_pkg::COND_ALWAYS:    take = 1'b1;
      dxs_pkg::COND_NOT_LAST:  take = ~stat_i.last_accept;
      dxs_pkg::COND_J_GE_CNT:  take = stat_i.j_ge_cnt;
      dxs_pkg::COND_J1_LT_CNT: take = stat_i.j1_lt_cnt;
      dxs_pkg::COND_I2_LT_CNT: take = stat_i.i2_lt_cnt;
      dxs_pkg::COND_I1_LT_CNT: take = stat_i.i1_lt_cnt;
      default:                 take = 1'b1;
    endcase
  end

  assign upc_d = take ? ctrl.target : dxs_pkg::step_t'(upc_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= dxs_pkg::STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> rtl/core/dxs_dp.sv
module dxs_dp #(
  parameter int unsigned ENTRIES = dxs_pkg::ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dxs_pkg::ctrl_t                       ctrl_i,
  input  logic                                 start_i,
  input  logic signed [dxs_pkg::SCORE_W-1:0]   key_score_i,
  input  logic [dxs_pkg::PAYLOAD_W-1:0]        payload_low_i,
  input  logic [dxs_pkg::PAYLOAD_W-1:0]        payload_high_i,
  input  logic                                 final_record_i,
  output dxs_pkg::stat_t                       stat_o,
  output logic                                 strobe_o,
  output logic signed [dxs_pkg::SCORE_W-1:0]   sorted_score_o,
  output logic [dxs_pkg::PAYLOAD_W-1:0]        sorted_payload_low_o,
  output logic [dxs_pkg::PAYLOAD_W-1:0]        sorted_payload_high_o,
  output logic                                 end_of_run_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  dxs_pkg::rec_t mem [ENTRIES];
  dxs_pkg::rec_t rd_q, cur_q, wdata;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [CW-1:0] i_inc, j_inc;
  logic [CW:0]   i_two;
  logic [CW-1:0] raddr, waddr;
  logic          accept, has_room, gt, we;
  logic          strobe_q, end_q;

  assign accept   = start_i & ~ctrl_i.busy;
  assign has_room = count_q < CW'(ENTRIES);
  assign i_inc    = i_q + 1'b1;
  assign j_inc    = j_q + 1'b1;
  assign i_two    = {1'b0, i_q} + (CW+1)'(2);
  assign gt       = $signed(rd_q.score) > $signed(cur_q.score);

  assign stat_o.last_accept = accept & final_record_i;
  assign stat_o.j_ge_cnt    = j_q >= count_q;
  assign stat_o.j1_lt_cnt   = j_inc < count_q;
  assign stat_o.i2_lt_cnt   = i_two < {1'b0, count_q};
  assign stat_o.i1_lt_cnt   = i_inc < count_q;

  always_comb begin
    case (ctrl_i.addr_sel)
      dxs_pkg::ADDR_ZERO: raddr = '0;
      dxs_pkg::ADDR_J:    raddr = j_q;
      dxs_pkg::ADDR_I1:   raddr = i_inc;
      dxs_pkg::ADDR_J1:   raddr = j_inc;
      default:            raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = count_q;
    wdata = cur_q;
    unique case (ctrl_i.wr_sel)
      dxs_pkg::WR_NONE: we = 1'b0;
      dxs_pkg::WR_LOAD: begin
        we    = accept & has_room;
        wdata = '{score: key_score_i, lo: payload_low_i, hi: payload_high_i};
      end
      dxs_pkg::WR_CUR_I: begin
        we    = 1'b1;
        waddr = i_q;
      end
      dxs_pkg::WR_CUR_J: begin
        // a larger later record takes over as the running record; the old one moves to position j
        we    = gt;
        waddr = j_q;
      end
      default: we = 1'b0;
    endcase
  end

  function automatic logic [CW-1:0] idx_next(dxs_pkg::idx_op_e op, logic [CW-1:0] cur,
                                             logic [CW-1:0] inc, logic [CW:0] two);
    logic [CW-1:0] r;
    case (op)
      dxs_pkg::IDX_HOLD: r = cur;
      dxs_pkg::IDX_ZERO: r = '0;
      dxs_pkg::IDX_ONE:  r = CW'(1);
      dxs_pkg::IDX_INC:  r = inc;
      dxs_pkg::IDX_I2:   r = two[CW-1:0];
      default:           r = cur;
    endcase
    return r;
  endfunction

  assign i_d = idx_next(ctrl_i.i_op, i_q, i_inc, i_two);
  assign j_d = idx_next(ctrl_i.j_op, j_q, j_inc, i_two);

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clr_count) begin
      count_d = '0;
    end else if (ctrl_i.wr_sel == dxs_pkg::WR_LOAD && accept && has_room) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      i_q      <= '0;
      j_q      <= '0;
      strobe_q <= 1'b0;
      end_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      i_q      <= i_d;
      j_q      <= j_d;
      strobe_q <= ctrl_i.emit;
      end_q    <= ctrl_i.emit & ~stat_o.i1_lt_cnt;
    end
  end

  // record memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[IW-1:0]] <= wdata;
    end
    rd_q <= mem[raddr[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cur_ld || (ctrl_i.wr_sel == dxs_pkg::WR_CUR_J && gt)) begin
      cur_q <= rd_q;
    end
    if (ctrl_i.emit) begin
      sorted_score_o        <= rd_q.score;
      sorted_payload_low_o  <= rd_q.lo;
      sorted_payload_high_o <= rd_q.hi;
    end
  end

  assign strobe_o     = strobe_q;
  assign end_of_run_o = end_q;

endmodule

>>> rtl/core/descending_exchange_sort.sv
// Collects up to ENTRIES scored records (one per cycle while busy is low) until a word
// with final_record_i set, then sorts them by signed score, largest first, equal
// scores keeping their exchange-sort order, and streams them out on strobe_o, one
// word per cycle, end_of_run_o marking the last. Records beyond ENTRIES are dropped.
// The receiver cannot stall: every strobed word must be taken in that cycle.
// After the final word, busy stays high while the record memory (one read and one write per
// cycle) does one compare-and-swap per cycle under a microcoded step counter and the
// sorted words are streamed out.
module descending_exchange_sort #(
  parameter int unsigned ENTRIES = dxs_pkg::ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [dxs_pkg::SCORE_W-1:0] key_score_i,
  input  logic [dxs_pkg::PAYLOAD_W-1:0]      payload_low_i,
  input  logic [dxs_pkg::PAYLOAD_W-1:0]      payload_high_i,
  input  logic                               final_record_i,
  output logic                               strobe_o,
  output logic signed [dxs_pkg::SCORE_W-1:0] sorted_score_o,
  output logic [dxs_pkg::PAYLOAD_W-1:0]      sorted_payload_low_o,
  output logic [dxs_pkg::PAYLOAD_W-1:0]      sorted_payload_high_o,
  output logic                               end_of_run_o
);

  dxs_pkg::ctrl_t ctrl;
  dxs_pkg::stat_t stat;

  dxs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  dxs_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .ctrl_i                (ctrl),
    .start_i               (start),
    .key_score_i           (key_score_i),
    .payload_low_i         (payload_low_i),
    .payload_high_i        (payload_high_i),
    .final_record_i        (final_record_i),
    .stat_o                (stat),
    .strobe_o              (strobe_o),
    .sorted_score_o        (sorted_score_o),
    .sorted_payload_low_o  (sorted_payload_low_o),
    .sorted_payload_high_o (sorted_payload_high_o),
    .end_of_run_o          (end_of_run_o)
  );

  assign busy = ctrl.busy;

endmodule

>>> rtl/core/dxs_checker.sv
`include "descending_exchange_sort_defines.svh"

module dxs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic final_record_i,
  input logic strobe_o,
  input logic end_of_run_o
);

  `DXS_ASSERT_NOW(a_eor_strobed, end_of_run_o, strobe_o, "end_of_run without strobe")
  `DXS_ASSERT_NOW(a_out_busy, strobe_o, busy, "output word while idle")
  `DXS_ASSERT_NEXT(a_eor_last, strobe_o && end_of_run_o, !strobe_o, "word after end of run")
  `DXS_ASSERT_NEXT(a_load_idle, start && !busy && !final_record_i, !busy,
                   "non-final word left idle")
  `DXS_ASSERT_NEXT(a_final_busy, start && !busy && final_record_i, busy && !strobe_o,
                   "final word did not start the sort")

endmodule

bind descending_exchange_sort dxs_checker u_dxs_checker (.*);

>>> dv/descending_exchange_sort_test.sv
`timescale 1ns / 100ps

module descending_exchange_sort_test;

  localparam int unsigned ENTRIES      = dxs_pkg::ENTRIES_DEF;
  localparam int unsigned DIR_ROWS     = 24;
  localparam int unsigned RANDOM_WORDS = 350;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    dxs_pkg::rec_t rec;
    logic          eor;
  } ranked_word_t;

  typedef struct packed {
    dxs_pkg::rec_t rec;
    logic          last;
    logic          typed;  // expected word written in the row, single-record sets only
    ranked_word_t  want;
  } dir_row_t;

  typedef enum logic [1:0] {
    SCORE_WIDE,
    SCORE_CLUSTER,
    SCORE_EDGES
  } score_mode_e;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [dxs_pkg::SCORE_W-1:0] key_score_i = '0;
  logic [dxs_pkg::PAYLOAD_W-1:0]      payload_low_i = '0;
  logic [dxs_pkg::PAYLOAD_W-1:0]      payload_high_i = '0;
  logic                               final_record_i = 1'b0;
  logic                               strobe_o;
  logic signed [dxs_pkg::SCORE_W-1:0] sorted_score_o;
  logic [dxs_pkg::PAYLOAD_W-1:0]      sorted_payload_low_o;
  logic [dxs_pkg::PAYLOAD_W-1:0]      sorted_payload_high_o;
  logic                               end_of_run_o;

  dxs_pkg::rec_t                      held_recs [ENTRIES];
  int unsigned                        held_count = 0;
  ranked_word_t                       fresh_ranks [$];
  ranked_word_t                       ranked_queue [$];
  ranked_word_t                       out_want;
  dir_row_t                           dir_rows [DIR_ROWS];
  int unsigned                        fault_count = 0;

  descending_exchange_sort #(
    .ENTRIES (ENTRIES)
  ) u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .key_score_i           (key_score_i),
    .payload_low_i         (payload_low_i),
    .payload_high_i        (payload_high_i),
    .final_record_i        (final_record_i),
    .strobe_o              (strobe_o),
    .sorted_score_o        (sorted_score_o),
    .sorted_payload_low_o  (sorted_payload_low_o),
    .sorted_payload_high_o (sorted_payload_high_o),
    .end_of_run_o          (end_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_fault(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    fault_count++;
  endtask

  // store a record; on the final word run the exchange sort, largest score first
  task automatic absorb_record(input dxs_pkg::rec_t r, input logic last);
    dxs_pkg::rec_t tmp;
    fresh_ranks.delete();
    if (held_count < ENTRIES) begin
      held_recs[held_count] = r;
      held_count++;
    end
    if (last) begin
      for (int i = 0; i < held_count; i++) begin
        for (int j = i + 1; j < held_count; j++) begin
          // strictly greater only: ties stay put
          if ($signed(held_recs[j].score) > $signed(held_recs[i].score)) begin
            tmp = held_recs[i];
            held_recs[i] = held_recs[j];
            held_recs[j] = tmp;
          end
        end
      end
      for (int k = 0; k < held_count; k++) begin
        fresh_ranks.push_back('{rec: held_recs[k], eor: (k + 1 == held_count)});
      end
      held_count = 0;
    end
  endtask

  task automatic send_word(input dxs_pkg::rec_t r, input logic last, input int unsigned gap,
                           input logic typed, input ranked_word_t want);
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start          <= 1'b1;
    key_score_i    <= r.score;
    payload_low_i  <= r.lo;
    payload_high_i <= r.hi;
    final_record_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    absorb_record(r, last);
    if (typed) begin
      ranked_queue.push_back(want);
    end else begin
      foreach (fresh_ranks[k]) ranked_queue.push_back(fresh_ranks[k]);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (ranked_queue.size() == 0) begin
        note_fault($sformatf("unexpected word, score %0d", sorted_score_o));
      end else begin
        out_want = ranked_queue.pop_front();
        if (sorted_score_o !== out_want.rec.score)
          note_fault($sformatf("score got %0d want %0d", sorted_score_o,
                               $signed(out_want.rec.score)));
        if (sorted_payload_low_o !== out_want.rec.lo)
          note_fault($sformatf("payload low got %h want %h", sorted_payload_low_o,
                               out_want.rec.lo));
        if (sorted_payload_high_o !== out_want.rec.hi)
          note_fault($sformatf("payload high got %h want %h", sorted_payload_high_o,
                               out_want.rec.hi));
        if (end_of_run_o !== out_want.eor)
          note_fault($sformatf("end of run got %b want %b", end_of_run_o, out_want.eor));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("descending_exchange_sort test failed");
    $finish;
  end

  initial begin
    dxs_pkg::rec_t r;
    int unsigned   sent;
    int unsigned   set_len;
    int unsigned   pick;
    int unsigned   gap;
    logic          quiet;
    score_mode_e   mode;

    // single-record sets at both score extremes
    dir_rows[0] = '{rec: '{score: 32'h7FFF_FFFF, lo: 64'hFFFF_FFFF_FFFF_FFFF,
                           hi: 64'hFFFF_FFFF_FFFF_FFFF},
                    last: 1'b1, typed: 1'b1,
                    want: '{rec: '{score: 32'h7FFF_FFFF, lo: 64'hFFFF_FFFF_FFFF_FFFF,
                                   hi: 64'hFFFF_FFFF_FFFF_FFFF}, eor: 1'b1}};
    dir_rows[1] = '{rec: '{score: 32'h8000_0000, lo: 64'h0, hi: 64'h0},
                    last: 1'b1, typed: 1'b1,
                    want: '{rec: '{score: 32'h8000_0000, lo: 64'h0, hi: 64'h0}, eor: 1'b1}};
    // short set with a tie on -1
    dir_rows[2] = '{rec: '{score: 32'h0000_0000, lo: 64'h0123_4567_89AB_CDEF,
                           hi: 64'hFEDC_BA98_7654_3210}, last: 1'b0, typed: 1'b0, want: '0};
    dir_rows[3] = '{rec: '{score: 32'hFFFF_FFFF, lo: 64'h1111_1111_1111_1111,
                           hi: 64'h2222_2222_2222_2222}, last: 1'b0, typed: 1'b0, want: '0};
    dir_rows[4] = '{rec: '{score: 32'h7FFF_FFFF, lo: 64'h3333_3333_3333_3333,
                           hi: 64'h4444_4444_4444_4444}, last: 1'b0, typed: 1'b0, want: '0};
    dir_rows[5] = '{rec: '{score: 32'hFFFF_FFFF, lo: 64'h5555_5555_5555_5555,
                           hi: 64'h6666_6666_6666_6666}, last: 1'b1, typed: 1'b0, want: '0};
    // full store with heavy ties, then two words that must be dropped, the final one too
    for (int k = 0; k < ENTRIES; k++) begin
      dir_rows[6 + k] = '{rec: '{score: (k % 3 == 0) ? 32'h8000_0000 :
                                        (k % 3 == 1) ? 32'd5 : 32'hFFFF_FFFB,
                                 lo: {32'hA5A5_A5A5, 32'(k)}, hi: {32'(k), 32'h5A5A_5A5A}},
                          last: 1'b0, typed: 1'b0, want: '0};
    end
    dir_rows[22] = '{rec: '{score: 32'h7FFF_FFFF, lo: 64'hDEAD_0000_0000_0001,
                            hi: 64'hDEAD_0000_0000_0002}, last: 1'b0, typed: 1'b0, want: '0};
    dir_rows[23] = '{rec: '{score: 32'h7FFF_FFFF, lo: 64'hDEAD_0000_0000_0003,
                            hi: 64'hDEAD_0000_0000_0004}, last: 1'b1, typed: 1'b0, want: '0};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int k = 0; k < DIR_ROWS; k++) begin
      send_word(dir_rows[k].rec, dir_rows[k].last, $urandom_range(0, 7),
                dir_rows[k].typed, dir_rows[k].want);
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        set_len = $urandom_range(ENTRIES + 1, ENTRIES + 4);  // overflow
      else if (pick < 3)
        set_len = $urandom_range(1, 3);
      else
        set_len = $urandom_range(4, ENTRIES);
      mode  = score_mode_e'($urandom_range(0, 2));
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++) begin
        case (mode)
          SCORE_WIDE:    r.score = $urandom;
          SCORE_CLUSTER: r.score = $urandom_range(0, 6) - 3;
          default: begin
            if ($urandom_range(0, 1))
              r.score = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else
              r.score = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
          end
        endcase
        r.lo = {$urandom, $urandom};
        r.hi = {$urandom, $urandom};
        gap  = quiet ? 0 : $urandom_range(0, 7);
        send_word(r, (k == set_len - 1), gap, 1'b0, '0);
        sent++;
      end
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (ranked_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("descending_exchange_sort test passed");
    end else begin
      $display("descending_exchange_sort test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/dxs_pkg.sv
rtl/core/dxs_seq.sv
rtl/core/dxs_dp.sv
rtl/core/descending_exchange_sort.sv
rtl/core/dxs_checker.sv
dv/descending_exchange_sort_test.sv
